>>> src/osa_pkg.sv
// ----------------------------------------------------------------------------
// osa_pkg
// Shared widths, op codes, control struct and arithmetic helpers for the
// oriented shape bounding box block.
// ----------------------------------------------------------------------------
package osa_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int ROT_FRAC_BITS = 14;
    localparam int ROT_W         = 16;
    localparam int ROW_W         = 3 * ROT_W;
    localparam int OUT_W         = 36;
    localparam int OP_W          = 3;
    localparam int PROD_W        = ROT_W + COORD_WIDTH;
    localparam int SUM_W         = PROD_W + 2;
    localparam int WIDE_W        = (PROD_W + 3 > OUT_W + 1) ? PROD_W + 3 : OUT_W + 1;

    localparam logic [OP_W-1:0] OP_BOX      = 3'd0;
    localparam logic [OP_W-1:0] OP_SPHERE   = 3'd1;
    localparam logic [OP_W-1:0] OP_CAPSULE  = 3'd2;
    localparam logic [OP_W-1:0] OP_CONE     = 3'd3;
    localparam logic [OP_W-1:0] OP_CYLINDER = 3'd4;
    localparam logic [OP_W-1:0] OP_POINT    = 3'd5;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic            valid;
        logic [OP_W-1:0] op;
        logic            last;
    } ctrl_t;

    function automatic logic [PROD_W-1:0] mag(input logic signed [PROD_W-1:0] x);
        mag = x[PROD_W-1] ? (PROD_W'(0) - x) : x;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [WIDE_W-1:0] x);
        if ((&x[WIDE_W-1:OUT_W-1]) || !(|x[WIDE_W-1:OUT_W-1])) begin
            sat_out = x[OUT_W-1:0];
        end else if (x[WIDE_W-1]) begin
            sat_out = OUT_MIN;
        end else begin
            sat_out = OUT_MAX;
        end
    endfunction

endpackage

>>> src/osa_front.sv
// ----------------------------------------------------------------------------
// osa_front
// Input register and the nine-lane rotation multiply stage. Operands are
// steered per op; the next stage sums product magnitudes for shapes.
// ----------------------------------------------------------------------------
module osa_front import osa_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [OP_W-1:0]               s_op,
    input  logic [ROW_W-1:0]              s_rot_row_x,
    input  logic [ROW_W-1:0]              s_rot_row_y,
    input  logic [ROW_W-1:0]              s_rot_row_z,
    input  logic signed [COORD_WIDTH-1:0] s_pos_x,
    input  logic signed [COORD_WIDTH-1:0] s_pos_y,
    input  logic signed [COORD_WIDTH-1:0] s_pos_z,
    input  logic signed [COORD_WIDTH-1:0] s_dim_a,
    input  logic signed [COORD_WIDTH-1:0] s_dim_b,
    input  logic signed [COORD_WIDTH-1:0] s_dim_c,
    input  logic                          s_last,
    input  logic                          back_ready,
    output ctrl_t                         ctrl_o,
    output logic signed [PROD_W-1:0]      prod_o [3][3],
    output logic signed [COORD_WIDTH-1:0] pos_o [3],
    output logic signed [COORD_WIDTH-1:0] rad_o
);

    ctrl_t                          c1_reg, c1_next;
    ctrl_t                          c2_reg, c2_next;
    logic [ROW_W-1:0]               row_reg [3];
    logic signed [COORD_WIDTH-1:0]  pos1_reg [3];
    logic signed [COORD_WIDTH-1:0]  dim_reg [3];
    logic signed [COORD_WIDTH-1:0]  opnd [3];
    logic signed [PROD_W-1:0]       prod [3][3];
    logic signed [PROD_W-1:0]       prod_reg [3][3];
    logic signed [COORD_WIDTH-1:0]  pos2_reg [3];
    logic signed [COORD_WIDTH-1:0]  rad_reg;
    logic                           adv2;

    assign adv2    = !c2_reg.valid || back_ready;
    assign s_ready = !c1_reg.valid || adv2;

    always_comb begin
        c1_next = c1_reg;
        c2_next = c2_reg;
        if (adv2) begin
            c2_next = c1_reg;
        end
        if (s_ready) begin
            c1_next.valid = s_valid;
            c1_next.op    = s_op;
            c1_next.last  = s_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
        end else begin
            c1_reg <= c1_next;
            c2_reg <= c2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            row_reg[0]  <= s_rot_row_x;
            row_reg[1]  <= s_rot_row_y;
            row_reg[2]  <= s_rot_row_z;
            pos1_reg[0] <= s_pos_x;
            pos1_reg[1] <= s_pos_y;
            pos1_reg[2] <= s_pos_z;
            dim_reg[0]  <= s_dim_a;
            dim_reg[1]  <= s_dim_b;
            dim_reg[2]  <= s_dim_c;
        end
    end

    // column operands: cone/cylinder use radius twice, capsule/cone/cylinder length in col 2
    always_comb begin
        opnd[0] = dim_reg[0];
        opnd[1] = (c1_reg.op == OP_CONE || c1_reg.op == OP_CYLINDER) ? dim_reg[0] : dim_reg[1];
        opnd[2] = (c1_reg.op == OP_BOX || c1_reg.op == OP_POINT) ? dim_reg[2] : dim_reg[1];
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod[i][j] = PROD_W'($signed(row_reg[i][ROT_W*j +: ROT_W]))
                           * PROD_W'(opnd[j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2 && c1_reg.valid) begin
            prod_reg <= prod;
            pos2_reg <= pos1_reg;
            rad_reg  <= dim_reg[0];
        end
    end

    assign ctrl_o = c2_reg;
    assign prod_o = prod_reg;
    assign pos_o  = pos2_reg;
    assign rad_o  = rad_reg;

endmodule

>>> src/osa_bound.sv
// ----------------------------------------------------------------------------
// osa_bound
// Half-extent and hull fold per axis, running min/max accumulator and the
// result register.
// ----------------------------------------------------------------------------
module osa_bound import osa_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ctrl_t                         ctrl_i,
    input  logic signed [PROD_W-1:0]      prod_i [3][3],
    input  logic signed [COORD_WIDTH-1:0] pos_i [3],
    input  logic signed [COORD_WIDTH-1:0] rad_i,
    output logic                          back_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [OUT_W-1:0]       min_o [3],
    output logic signed [OUT_W-1:0]       max_o [3]
);

    logic                       m_valid_reg, m_valid_next;
    logic signed [OUT_W-1:0]    acc_lo_reg [3], acc_lo_next [3];
    logic signed [OUT_W-1:0]    acc_hi_reg [3], acc_hi_next [3];
    logic signed [OUT_W-1:0]    min_reg [3];
    logic signed [OUT_W-1:0]    max_reg [3];
    logic signed [OUT_W-1:0]    lo [3];
    logic signed [OUT_W-1:0]    hi [3];
    logic signed [OUT_W-1:0]    fold_lo [3];
    logic signed [OUT_W-1:0]    fold_hi [3];
    logic signed [OUT_W-1:0]    q_sat [3];
    logic [PROD_W-1:0]          m0 [3], m1 [3], m2 [3];
    logic [SUM_W-1:0]           sum3 [3], sum2 [3];
    logic signed [WIDE_W-1:0]   half_len [3];
    logic signed [WIDE_W-1:0]   h [3];
    logic signed [WIDE_W-1:0]   pw [3];
    logic signed [WIDE_W-1:0]   psum [3];
    logic signed [WIDE_W-1:0]   q [3];
    logic                       is_point, is_shape, emits, out_free, take;

    assign is_point   = (ctrl_i.op == OP_POINT);
    assign is_shape   = (ctrl_i.op == OP_BOX) || (ctrl_i.op == OP_SPHERE)
                     || (ctrl_i.op == OP_CAPSULE) || (ctrl_i.op == OP_CONE)
                     || (ctrl_i.op == OP_CYLINDER);
    assign emits      = is_shape || (is_point && ctrl_i.last);
    assign out_free   = !m_valid_reg || m_ready;
    assign back_ready = !ctrl_i.valid || !emits || out_free;
    assign take       = ctrl_i.valid && back_ready;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m0[i]   = mag(prod_i[i][0]);
            m1[i]   = mag(prod_i[i][1]);
            m2[i]   = mag(prod_i[i][2]);
            sum3[i] = SUM_W'(m0[i]) + SUM_W'(m1[i]) + SUM_W'(m2[i]);
            sum2[i] = SUM_W'(m0[i]) + SUM_W'(m1[i]);
            half_len[i] = WIDE_W'(m2[i] >> (ROT_FRAC_BITS + 1));
            pw[i]   = WIDE_W'(pos_i[i]);
            case (ctrl_i.op)
                OP_BOX:      h[i] = WIDE_W'(sum3[i] >> (ROT_FRAC_BITS + 1));
                OP_SPHERE:   h[i] = WIDE_W'(rad_i);
                OP_CAPSULE:  h[i] = half_len[i] + WIDE_W'(rad_i);
                OP_CONE,
                OP_CYLINDER: h[i] = WIDE_W'(sum2[i] >> ROT_FRAC_BITS) + half_len[i];
                default:     h[i] = '0;
            endcase
            lo[i]   = sat_out(pw[i] - h[i]);
            hi[i]   = sat_out(pw[i] + h[i]);
            psum[i] = WIDE_W'(prod_i[i][0]) + WIDE_W'(prod_i[i][1]) + WIDE_W'(prod_i[i][2]);
            q[i]    = (psum[i] >>> ROT_FRAC_BITS) + pw[i];
            q_sat[i]   = sat_out(q[i]);
            fold_lo[i] = (q_sat[i] < acc_lo_reg[i]) ? q_sat[i] : acc_lo_reg[i];
            fold_hi[i] = (q_sat[i] > acc_hi_reg[i]) ? q_sat[i] : acc_hi_reg[i];
        end
    end

    always_comb begin
        acc_lo_next  = acc_lo_reg;
        acc_hi_next  = acc_hi_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (take && is_point) begin
            for (int i = 0; i < 3; i++) begin
                acc_lo_next[i] = ctrl_i.last ? OUT_MAX : fold_lo[i];
                acc_hi_next[i] = ctrl_i.last ? OUT_MIN : fold_hi[i];
            end
        end
        if (take && emits) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                acc_lo_reg[i] <= OUT_MAX;
                acc_hi_reg[i] <= OUT_MIN;
            end
        end else begin
            m_valid_reg <= m_valid_next;
            acc_lo_reg  <= acc_lo_next;
            acc_hi_reg  <= acc_hi_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && emits) begin
            for (int i = 0; i < 3; i++) begin
                min_reg[i] <= is_point ? fold_lo[i] : lo[i];
                max_reg[i] <= is_point ? fold_hi[i] : hi[i];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign min_o   = min_reg;
    assign max_o   = max_reg;

endmodule

>>> src/oriented_shape_aabb.sv
// ----------------------------------------------------------------------------
// oriented_shape_aabb
// Axis-aligned bounds of a rotated box, sphere, capsule, cone or cylinder,
// and running bounds of a stream of convex hull points.
//
//   channel  ports       carries
//   request  s_*         op, rotation rows, position, dims, last
//   result   m_*         min_x/y/z, max_x/y/z (Q20.16, saturated)
//
// One request per cycle sustained while results are taken; an accepted
// request passes the input register, multiply register and result register.
// Hull points without last and unknown ops give no result.
// Synchronous active-low reset empties the hull box and drops queued work.
// A stalled result holds the stages behind it; empty stages still fill.
// ----------------------------------------------------------------------------
module oriented_shape_aabb import osa_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [OP_W-1:0]               s_op,
    input  logic [ROW_W-1:0]              s_rot_row_x,
    input  logic [ROW_W-1:0]              s_rot_row_y,
    input  logic [ROW_W-1:0]              s_rot_row_z,
    input  logic signed [COORD_WIDTH-1:0] s_pos_x,
    input  logic signed [COORD_WIDTH-1:0] s_pos_y,
    input  logic signed [COORD_WIDTH-1:0] s_pos_z,
    input  logic signed [COORD_WIDTH-1:0] s_dim_a,
    input  logic signed [COORD_WIDTH-1:0] s_dim_b,
    input  logic signed [COORD_WIDTH-1:0] s_dim_c,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [OUT_W-1:0]       m_min_x,
    output logic signed [OUT_W-1:0]       m_min_y,
    output logic signed [OUT_W-1:0]       m_min_z,
    output logic signed [OUT_W-1:0]       m_max_x,
    output logic signed [OUT_W-1:0]       m_max_y,
    output logic signed [OUT_W-1:0]       m_max_z
);

    ctrl_t                          ctrl;
    logic signed [PROD_W-1:0]       prod [3][3];
    logic signed [COORD_WIDTH-1:0]  pos [3];
    logic signed [COORD_WIDTH-1:0]  rad;
    logic                           back_ready;
    logic signed [OUT_W-1:0]        min_v [3];
    logic signed [OUT_W-1:0]        max_v [3];

    osa_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_rot_row_x (s_rot_row_x),
        .s_rot_row_y (s_rot_row_y),
        .s_rot_row_z (s_rot_row_z),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_pos_z     (s_pos_z),
        .s_dim_a     (s_dim_a),
        .s_dim_b     (s_dim_b),
        .s_dim_c     (s_dim_c),
        .s_last      (s_last),
        .back_ready  (back_ready),
        .ctrl_o      (ctrl),
        .prod_o      (prod),
        .pos_o       (pos),
        .rad_o       (rad)
    );

    osa_bound u_bound (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl_i     (ctrl),
        .prod_i     (prod),
        .pos_i      (pos),
        .rad_i      (rad),
        .back_ready (back_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .min_o      (min_v),
        .max_o      (max_v)
    );

    assign m_min_x = min_v[0];
    assign m_min_y = min_v[1];
    assign m_min_z = min_v[2];
    assign m_max_x = max_v[0];
    assign m_max_y = max_v[1];
    assign m_max_z = max_v[2];

endmodule

>>> bench/oriented_shape_aabb_test.sv
// ----------------------------------------------------------------------------
// oriented_shape_aabb_test
// Drives boxes, spheres, capsules, cones, cylinders and convex hull point runs
// into oriented_shape_aabb under random sender gaps and receiver stalls. Each
// accepted request is run through a local bounds predictor, and each result
// is checked field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module oriented_shape_aabb_test;
    import osa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1600;
    localparam int MODE_CHUNK   = 150;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 8;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam logic [ROT_W-1:0] ROT_ONE  = 16'h4000;
    localparam logic [ROT_W-1:0] ROT_ZERO = 16'h0000;
    localparam logic [ROT_W-1:0] ROT_MIN  = 16'h8000;
    localparam logic [ROT_W-1:0] ROT_MAX  = 16'h7fff;

    localparam logic [COORD_WIDTH-1:0] COORD_MIN = 32'h8000_0000;
    localparam logic [COORD_WIDTH-1:0] COORD_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic [OP_W-1:0]             op;
        logic [2:0][ROW_W-1:0]       rows;
        logic [2:0][COORD_WIDTH-1:0] pos;
        logic [2:0][COORD_WIDTH-1:0] dim;
        logic                        last;
    } shape_req_t;

    // corners 0..2 are min x/y/z, 3..5 are max x/y/z
    typedef logic [5:0][OUT_W-1:0] bounds_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [OP_W-1:0]               s_op = '0;
    logic [ROW_W-1:0]              s_rot_row_x = '0;
    logic [ROW_W-1:0]              s_rot_row_y = '0;
    logic [ROW_W-1:0]              s_rot_row_z = '0;
    logic signed [COORD_WIDTH-1:0] s_pos_x = '0;
    logic signed [COORD_WIDTH-1:0] s_pos_y = '0;
    logic signed [COORD_WIDTH-1:0] s_pos_z = '0;
    logic signed [COORD_WIDTH-1:0] s_dim_a = '0;
    logic signed [COORD_WIDTH-1:0] s_dim_b = '0;
    logic signed [COORD_WIDTH-1:0] s_dim_c = '0;
    logic                          s_last = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [OUT_W-1:0]       m_min_x;
    logic signed [OUT_W-1:0]       m_min_y;
    logic signed [OUT_W-1:0]       m_min_z;
    logic signed [OUT_W-1:0]       m_max_x;
    logic signed [OUT_W-1:0]       m_max_y;
    logic signed [OUT_W-1:0]       m_max_z;

    bounds_t pending_bounds [$];
    longint  hull_lo [3];
    longint  hull_hi [3];
    string   corner_tag [6] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};

    bit       tx_idle = 1'b0;
    bit       rx_stall = 1'b0;
    int       burst_left = 0;
    bit [3:0] rx_phase = '0;
    bit [15:0] rx_pattern = '1;

    int err_cnt = 0;
    int n_checked = 0;
    int n_shapes = 0;
    int n_points = 0;
    int n_hulls = 0;
    int n_ignored = 0;

    oriented_shape_aabb i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_rot_row_x (s_rot_row_x),
        .s_rot_row_y (s_rot_row_y),
        .s_rot_row_z (s_rot_row_z),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_pos_z     (s_pos_z),
        .s_dim_a     (s_dim_a),
        .s_dim_b     (s_dim_b),
        .s_dim_c     (s_dim_c),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_min_x     (m_min_x),
        .m_min_y     (m_min_y),
        .m_min_z     (m_min_z),
        .m_max_x     (m_max_x),
        .m_max_y     (m_max_y),
        .m_max_z     (m_max_z)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // ------------------------------------------------------------------
    // bounds predictor
    // ------------------------------------------------------------------
    function automatic longint abs_val(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint sat36(input longint x);
        if (x > longint'(OUT_MAX)) begin
            return longint'(OUT_MAX);
        end
        if (x < longint'(OUT_MIN)) begin
            return longint'(OUT_MIN);
        end
        return x;
    endfunction

    function automatic void hull_clear();
        for (int i = 0; i < 3; i++) begin
            hull_lo[i] = longint'(OUT_MAX);
            hull_hi[i] = longint'(OUT_MIN);
        end
    endfunction

    function automatic bit predict_bounds(input shape_req_t r, output bounds_t b);
        longint rm [3][3];
        longint pos [3];
        longint d [3];
        longint h;
        longint q;
        b = '0;
        if (r.op > OP_POINT) begin
            return 1'b0;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                rm[i][j] = longint'($signed(r.rows[i][ROT_W*j +: ROT_W]));
            end
            pos[i] = longint'($signed(r.pos[i]));
            d[i]   = longint'($signed(r.dim[i]));
        end
        if (r.op == OP_POINT) begin
            for (int i = 0; i < 3; i++) begin
                q = sat36(((rm[i][0] * d[0] + rm[i][1] * d[1] + rm[i][2] * d[2])
                          >>> ROT_FRAC_BITS) + pos[i]);
                if (q < hull_lo[i]) begin
                    hull_lo[i] = q;
                end
                if (q > hull_hi[i]) begin
                    hull_hi[i] = q;
                end
            end
            if (!r.last) begin
                return 1'b0;
            end
            for (int i = 0; i < 3; i++) begin
                b[i]     = OUT_W'(hull_lo[i]);
                b[3 + i] = OUT_W'(hull_hi[i]);
            end
            hull_clear();
            return 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
            case (r.op)
                OP_BOX: begin
                    h = (abs_val(rm[i][0] * d[0]) + abs_val(rm[i][1] * d[1])
                        + abs_val(rm[i][2] * d[2])) >> (ROT_FRAC_BITS + 1);
                end
                OP_SPHERE: begin
                    h = d[0];
                end
                OP_CAPSULE: begin
                    h = (abs_val(rm[i][2] * d[1]) >> (ROT_FRAC_BITS + 1)) + d[0];
                end
                default: begin
                    h = ((abs_val(rm[i][0] * d[0]) + abs_val(rm[i][1] * d[0]))
                        >> ROT_FRAC_BITS)
                      + (abs_val(rm[i][2] * d[1]) >> (ROT_FRAC_BITS + 1));
                end
            endcase
            b[i]     = OUT_W'(sat36(pos[i] - h));
            b[3 + i] = OUT_W'(sat36(pos[i] + h));
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // random content
    // ------------------------------------------------------------------
    function automatic logic [ROT_W-1:0] rand_rot_entry();
        logic [ROT_W-1:0] picks [5];
        int v;
        picks = '{ROT_MIN, ROT_MAX, ROT_ZERO, ROT_ONE, 16'hc000};
        case ($urandom_range(0, 3))
            0: begin
                return ROT_W'($urandom);
            end
            3: begin
                return picks[$urandom_range(0, 4)];
            end
            default: begin
                v = int'($urandom_range(0, 32768)) - 16384;
                return v[ROT_W-1:0];
            end
        endcase
    endfunction

    function automatic logic [COORD_WIDTH-1:0] rand_coord();
        logic [COORD_WIDTH-1:0] picks [5];
        int v;
        picks = '{COORD_MIN, COORD_MAX, '0, '1, 32'h0001_0000};
        case ($urandom_range(0, 3))
            0: begin
                return $urandom;
            end
            3: begin
                return picks[$urandom_range(0, 4)];
            end
            default: begin
                v = int'($urandom_range(0, 1 << 24)) - (1 << 23);
                return v;
            end
        endcase
    endfunction

    function automatic shape_req_t rand_req(input logic [OP_W-1:0] op, input logic last);
        shape_req_t r;
        r.op = op;
        r.last = last;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r.rows[i][ROT_W*j +: ROT_W] = rand_rot_entry();
            end
            r.pos[i] = rand_coord();
            r.dim[i] = rand_coord();
        end
        return r;
    endfunction

    function automatic logic [2:0][ROW_W-1:0] identity_rows();
        return {{ROT_ONE, ROT_ZERO, ROT_ZERO},
                {ROT_ZERO, ROT_ONE, ROT_ZERO},
                {ROT_ZERO, ROT_ZERO, ROT_ONE}};
    endfunction

    function automatic logic [OP_W-1:0] rand_spare_op();
        return ($urandom_range(0, 1) == 1) ? OP_SPARE_HI : OP_SPARE_LO;
    endfunction

    // ------------------------------------------------------------------
    // request driver: called at a falling edge, returns at a falling edge
    // ------------------------------------------------------------------
    task automatic send_req(input shape_req_t r);
        int gap;
        bounds_t b;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = tx_idle ? $urandom_range(1, 8) : 0;
            repeat (gap) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_op        <= r.op;
        s_rot_row_x <= r.rows[0];
        s_rot_row_y <= r.rows[1];
        s_rot_row_z <= r.rows[2];
        s_pos_x     <= r.pos[0];
        s_pos_y     <= r.pos[1];
        s_pos_z     <= r.pos[2];
        s_dim_a     <= r.dim[0];
        s_dim_b     <= r.dim[1];
        s_dim_c     <= r.dim[2];
        s_last      <= r.last;
        do @(posedge aclk); while (!s_ready);
        if (predict_bounds(r, b)) begin
            pending_bounds.push_back(b);
        end
        if (r.op > OP_POINT) begin
            n_ignored++;
        end else if (r.op == OP_POINT) begin
            n_points++;
            n_hulls += int'(r.last);
        end else begin
            n_shapes++;
        end
        burst_left--;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // receiver stalls: 16-bit ready pattern, reloaded each wrap
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (rx_phase == 0) begin
            case ($urandom_range(0, 2))
                0: rx_pattern = 16'($urandom);
                1: rx_pattern = 16'($urandom | $urandom);
                default: rx_pattern = 16'($urandom & $urandom);
            endcase
        end
        m_ready <= rx_stall ? rx_pattern[rx_phase] : 1'b1;
        rx_phase = rx_phase + 1'b1;
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        bounds_t got;
        bounds_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_max_z, m_max_y, m_max_x, m_min_z, m_min_y, m_min_x};
            n_checked++;
            if (pending_bounds.size() == 0) begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS) begin
                    $display("tb: result %0d arrived with nothing pending", n_checked);
                end
            end else begin
                want = pending_bounds.pop_front();
                for (int k = 0; k < 6; k++) begin
                    if (got[k] !== want[k]) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS) begin
                            $display("tb: result %0d %s expected %0d got %0d", n_checked,
                                     corner_tag[k], $signed(want[k]), $signed(got[k]));
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_box_extremes();
        shape_req_t r;
        r = rand_req(OP_BOX, 1'b0);
        r.rows = identity_rows();
        r.pos = '0;
        r.dim = {32'h0003_0000, 32'h0002_0000, 32'h0001_0000};
        send_req(r);
        r.rows = {9{ROT_MIN}};
        r.dim = {3{COORD_MIN}};
        r.pos = {3{COORD_MAX}};
        send_req(r);
        r.rows = {9{ROT_MAX}};
        r.dim = {3{COORD_MAX}};
        r.pos = {3{COORD_MIN}};
        send_req(r);
        r = rand_req(OP_BOX, 1'b0);
        r.rows = '0;
        r.dim = '0;
        send_req(r);
    endtask

    task automatic test_round_shapes();
        shape_req_t r;
        for (int k = int'(OP_SPHERE); k <= int'(OP_CYLINDER); k++) begin
            send_req(rand_req(OP_W'(k), 1'b0));
            r = rand_req(OP_W'(k), 1'b0);
            r.rows = {9{ROT_MIN}};
            r.dim = {COORD_MAX, COORD_MIN, COORD_MAX};
            r.pos = {COORD_MAX, COORD_MIN, COORD_MAX};
            send_req(r);
        end
    endtask

    // negative radius turns the bounds inside out
    task automatic test_negative_radius();
        shape_req_t r;
        r = rand_req(OP_SPHERE, 1'b0);
        r.dim[0] = 32'hfffe_0000;
        send_req(r);
        r = rand_req(OP_CAPSULE, 1'b0);
        r.rows = identity_rows();
        r.dim = {32'h0, 32'h0001_0000, 32'hfffc_0000};
        send_req(r);
    endtask

    task automatic test_spare_ops();
        send_req(rand_req(OP_SPARE_LO, 1'b0));
        send_req(rand_req(OP_SPARE_HI, 1'b1));
    endtask

    // last on a shape must leave the open hull alone
    task automatic test_hull_points();
        shape_req_t r;
        r = rand_req(OP_POINT, 1'b0);
        r.rows = {9{ROT_MIN}};
        r.dim = {3{COORD_MIN}};
        r.pos = {3{COORD_MAX}};
        send_req(r);
        send_req(rand_req(OP_SPHERE, 1'b1));
        r.rows = {9{ROT_MAX}};
        r.dim = {COORD_MAX, COORD_MIN, COORD_MAX};
        r.pos = {3{COORD_MIN}};
        send_req(r);
        send_req(rand_req(OP_POINT, 1'b1));
        send_req(rand_req(OP_POINT, 1'b1));
    endtask

    task automatic test_random_mix();
        shape_req_t base;
        shape_req_t r;
        int sent;
        int next_switch;
        int run_len;
        sent = 0;
        next_switch = MODE_CHUNK;
        tx_idle = 1'b0;
        rx_stall = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= next_switch) begin
                next_switch += MODE_CHUNK;
                tx_idle  = ($urandom_range(0, 2) != 0);
                rx_stall = ($urandom_range(0, 2) != 0);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    send_req(rand_req(OP_W'($urandom_range(OP_BOX, OP_CYLINDER)),
                                      ($urandom_range(0, 3) == 0)));
                    sent++;
                end
                9: begin
                    send_req(rand_req(rand_spare_op(), 1'($urandom_range(0, 1))));
                end
                default: begin
                    // hull run mostly sharing one pose, points random
                    run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                          : $urandom_range(1, 8);
                    base = rand_req(OP_POINT, 1'b0);
                    for (int p = 0; p < run_len; p++) begin
                        if ($urandom_range(0, 15) == 0) begin
                            r = rand_req(OP_W'($urandom_range(OP_BOX, OP_CYLINDER)), 1'b1);
                            send_req(r);
                            sent++;
                        end else if ($urandom_range(0, 15) == 0) begin
                            send_req(rand_req(rand_spare_op(), 1'b1));
                        end
                        r = ($urandom_range(0, 3) == 0) ? rand_req(OP_POINT, 1'b0) : base;
                        r.dim = {rand_coord(), rand_coord(), rand_coord()};
                        r.last = (p == run_len - 1);
                        send_req(r);
                        sent++;
                    end
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        int waited;
        hull_clear();
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_box_extremes();
        test_round_shapes();
        test_negative_radius();
        test_spare_ops();
        test_hull_points();
        test_random_mix();
        s_valid <= 1'b0;

        waited = 0;
        while (pending_bounds.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_bounds.size() != 0) begin
            err_cnt += pending_bounds.size();
            $display("tb: %0d results never arrived", pending_bounds.size());
        end

        $display("tb: covered %0d shapes, %0d hull points closing %0d hulls, %0d spare ops",
                 n_shapes, n_points, n_hulls, n_ignored);
        $display("tb: %0d results compared, %0d field errors", n_checked, err_cnt);
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> oriented_shape_aabb.f
src/osa_pkg.sv
src/osa_front.sv
src/osa_bound.sv
src/oriented_shape_aabb.sv
bench/oriented_shape_aabb_test.sv
